// ===== design/matrix4_transform_unit_macros.svh =====
// Assertion macros for the matrix transform unit.
`ifndef MATRIX4_TRANSFORM_UNIT_MACROS_SVH
`define MATRIX4_TRANSFORM_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset.
`define M4TU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("m4tu assertion failed");

// Check that a condition never holds outside reset.
`define M4TU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("m4tu forbidden condition seen");

`else

`define M4TU_ASSERT(lbl, clk, rst_n, prop)
`define M4TU_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== design/m4tu_pkg.sv =====
package m4tu_pkg;

    localparam int WORD_W        = 32;
    localparam int DIM           = 4;
    localparam int ROW_W         = 2;
    localparam int MODE_W        = 2;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [DIM-1:0]          word_vec_t;

    // Input operation codes
    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_XFORM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd2;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(DIM - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_PUSH
    } state_t;

    // Storage write strobes for one lane
    typedef struct packed {
        logic             a_we;
        logic             b_we;
        logic [ROW_W-1:0] row;
    } lane_wr_t;

    // Multiply-accumulate control shared by all lanes
    typedef struct packed {
        logic             issue;
        logic             first;
        logic             compose;
        logic [ROW_W-1:0] k;
    } lane_ctl_t;

    // Output register load request
    typedef struct packed {
        logic             load;
        logic [ROW_W-1:0] row;
        logic             last;
    } push_t;

endpackage

// ===== design/m4tu_in_if.sv =====
interface m4tu_in_if import m4tu_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ROW_W-1:0]  row_sel;
    word_t             elem0;
    word_t             elem1;
    word_t             elem2;
    word_t             elem3;

    modport source (output valid, mode, row_sel, elem0, elem1, elem2, elem3, input ready);
    modport sink   (input valid, mode, row_sel, elem0, elem1, elem2, elem3, output ready);

endinterface

// ===== design/m4tu_out_if.sv =====
interface m4tu_out_if import m4tu_pkg::*; ();

    logic             valid;
    logic             ready;
    word_t            out0;
    word_t            out1;
    word_t            out2;
    word_t            out3;
    logic [ROW_W-1:0] out_row;
    logic             last;
    logic             overflow;

    modport source (output valid, out0, out1, out2, out3, out_row, last, overflow,
                    input ready);
    modport sink   (input valid, out0, out1, out2, out3, out_row, last, overflow,
                    output ready);

endinterface

// ===== design/m4tu_lane.sv =====
module m4tu_lane import m4tu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int LANE      = 0,
    localparam int PROD_W   = 2 * WORD_W,
    localparam int ACC_W    = PROD_W - FRAC_BITS + 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_wr_t                wr,
    input  word_vec_t               elem,
    input  lane_ctl_t               ctl,
    input  word_t                   a_bcast,
    input  word_t                   v_bcast,
    output word_t                   a_rd,
    output logic signed [ACC_W-1:0] acc
);

    localparam word_t ONE = word_t'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    word_t                    a_row_reg [DIM];
    word_t                    b_col_reg [DIM];
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     first_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    word_t                    a_op;
    word_t                    b_op;
    logic signed [PROD_W-1:0] rnd;
    logic signed [ACC_W-1:0]  term;

    // Hold this lane's row of A and column of B
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIM; i++)
            begin
                a_row_reg[i] <= (i == LANE) ? ONE : '0;
                b_col_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.a_we)
            begin
                for (int i = 0; i < DIM; i++)
                begin
                    a_row_reg[i] <= elem[i];
                end
            end
            if (wr.b_we)
            begin
                b_col_reg[wr.row] <= elem[LANE];
            end
        end
    end

    assign a_rd = a_row_reg[ctl.k];

    // Pick operands: own row times vector, or broadcast A element times own column
    always_comb
    begin
        a_op = ctl.compose ? a_bcast : a_row_reg[ctl.k];
        b_op = ctl.compose ? b_col_reg[ctl.k] : v_bcast;
    end

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.issue;
            first_reg    <= ctl.first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg <= PROD_W'(a_op) * PROD_W'(b_op);
        end
    end

    // Round to nearest, ties up, and accumulate exactly
    always_comb
    begin
        rnd      = prod_reg + HALF;
        term     = {{2{rnd[PROD_W-1]}}, rnd[PROD_W-1:FRAC_BITS]};
        acc_next = (first_reg ? '0 : acc_reg) + term;
    end

    always_ff @(posedge clk)
    begin
        if (prod_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== design/m4tu_merge.sv =====
module m4tu_merge import m4tu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int ACC_W    = 2 * WORD_W - FRAC_BITS + 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [ACC_W-1:0] acc [DIM],
    input  push_t                   push,
    output logic                    free,
    m4tu_out_if.source              out_ch
);

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - WORD_W + 1){1'b0}}, {(WORD_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W - WORD_W + 1){1'b1}}, {(WORD_W - 1){1'b0}}};

    word_t            sat_val [DIM];
    logic [DIM-1:0]   sat_hit;
    logic             valid_reg;
    word_t            val_reg [DIM];
    logic [ROW_W-1:0] row_reg;
    logic             last_reg;
    logic             ovf_reg;

    // Clamp each lane sum to the word range
    always_comb
    begin
        for (int j = 0; j < DIM; j++)
        begin
            if (acc[j] > SAT_HI)
            begin
                sat_val[j] = SAT_HI[WORD_W-1:0];
                sat_hit[j] = 1'b1;
            end
            else if (acc[j] < SAT_LO)
            begin
                sat_val[j] = SAT_LO[WORD_W-1:0];
                sat_hit[j] = 1'b1;
            end
            else
            begin
                sat_val[j] = acc[j][WORD_W-1:0];
                sat_hit[j] = 1'b0;
            end
        end
    end

    assign free = !valid_reg || out_ch.ready;

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.load)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                val_reg[j] <= sat_val[j];
            end
            row_reg  <= push.row;
            last_reg <= push.last;
            ovf_reg  <= |sat_hit;
        end
    end

    assign out_ch.valid    = valid_reg;
    assign out_ch.out0     = val_reg[0];
    assign out_ch.out1     = val_reg[1];
    assign out_ch.out2     = val_reg[2];
    assign out_ch.out3     = val_reg[3];
    assign out_ch.out_row  = row_reg;
    assign out_ch.last     = last_reg;
    assign out_ch.overflow = ovf_reg;

endmodule

// ===== design/matrix4_transform_unit.sv =====
// 4x4 fixed-point matrix unit, Q(32-FRAC_BITS).FRAC_BITS signed words.
// Input channel in_ch carries one word per command: mode, row_sel and four
// elements. Load-A and load-B words (row 0..2 for B) update the stored
// matrices in the accepting cycle and return nothing. A transform word
// returns one word A*v on out_ch, out_row 0 and last set. Loading row 3 of
// B returns the four rows of A*B in order, last set on row 3.
// Four lanes, one per result element, each run one 32x32 multiply a cycle
// over the four terms of a dot product; the merging stage clamps and flags.
// Each result row runs a five-step multiply-accumulate loop (four multiplies
// and a final add) and then the push step, which loads the output register;
// a transform runs this once, a compose once for each of the four rows.
// in_ch.ready is high while the sequencer is idle; a finished word may still
// sit in the output register then. If the receiver stalls, the next result
// waits in the lanes until the output register is free.
// Reset: A returns to identity, B to zero, the output register empties.
module matrix4_transform_unit import m4tu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    m4tu_in_if.sink   in_ch,
    m4tu_out_if.source out_ch
);

`include "matrix4_transform_unit_macros.svh"

    localparam int ACC_W = 2 * WORD_W - FRAC_BITS + 2;

    state_t           state_reg;
    state_t           state_next;
    logic [2:0]       k_reg;
    logic [2:0]       k_next;
    logic [ROW_W-1:0] r_reg;
    logic [ROW_W-1:0] r_next;
    logic             compose_reg;
    logic             compose_next;
    word_vec_t        vec_reg;

    logic             in_acc;
    word_vec_t        elem;
    lane_wr_t         wr [DIM];
    lane_ctl_t        ctl;
    push_t            push;
    logic             free;
    word_t            a_rd [DIM];
    logic signed [ACC_W-1:0] acc [DIM];

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign elem        = {in_ch.elem3, in_ch.elem2, in_ch.elem1, in_ch.elem0};

    // Hold the vector of a transform command
    always_ff @(posedge clk)
    begin
        if (in_acc && in_ch.mode == MODE_XFORM)
        begin
            vec_reg <= elem;
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            r_reg       <= '0;
            compose_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            r_reg       <= r_next;
            compose_reg <= compose_next;
        end
    end

    // Next state, lane control and output push
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        compose_next = compose_reg;
        push.load    = 1'b0;
        push.row     = compose_reg ? r_reg : '0;
        push.last    = !compose_reg || (r_reg == ROW_LAST);
        ctl.issue    = 1'b0;
        ctl.first    = (k_reg == 3'd0);
        ctl.compose  = compose_reg;
        ctl.k        = k_reg[ROW_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_ch.mode == MODE_XFORM)
                begin
                    state_next   = ST_MAC;
                    compose_next = 1'b0;
                    k_next       = '0;
                    r_next       = '0;
                end
                else if (in_acc && in_ch.mode == MODE_LOAD_B && in_ch.row_sel == ROW_LAST)
                begin
                    state_next   = ST_MAC;
                    compose_next = 1'b1;
                    k_next       = '0;
                    r_next       = '0;
                end
            end
            ST_MAC:
            begin
                ctl.issue = !k_reg[2];
                if (k_reg == 3'd4)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_PUSH:
            begin
                if (free)
                begin
                    push.load = 1'b1;
                    k_next    = '0;
                    if (compose_reg && r_reg != ROW_LAST)
                    begin
                        r_next     = r_reg + ROW_W'(1);
                        state_next = ST_MAC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Lanes, one per result element
    for (genvar j = 0; j < DIM; j++)
    begin : g_lane
        always_comb
        begin
            wr[j].a_we = in_acc && (in_ch.mode == MODE_LOAD_A)
                         && (in_ch.row_sel == ROW_W'(j));
            wr[j].b_we = in_acc && (in_ch.mode == MODE_LOAD_B);
            wr[j].row  = in_ch.row_sel;
        end

        m4tu_lane #(
            .FRAC_BITS (FRAC_BITS),
            .LANE      (j)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr[j]),
            .elem    (elem),
            .ctl     (ctl),
            .a_bcast (a_rd[r_reg]),
            .v_bcast (vec_reg[k_reg[ROW_W-1:0]]),
            .a_rd    (a_rd[j]),
            .acc     (acc[j])
        );
    end

    m4tu_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc    (acc),
        .push   (push),
        .free   (free),
        .out_ch (out_ch)
    );

    // Checks on the sequencer
    `M4TU_ASSERT(a_xform_starts, clk, rst_n,
        (in_acc && in_ch.mode == MODE_XFORM) |=> (state_reg == ST_MAC && k_reg == 3'd0))
    `M4TU_ASSERT_NEVER(a_no_overwrite, clk, rst_n,
        push.load && out_ch.valid && !out_ch.ready)
    `M4TU_ASSERT(a_push_after_mac, clk, rst_n,
        (state_reg == ST_PUSH) |-> ($past(state_reg) == ST_MAC || $past(state_reg) == ST_PUSH))
    `M4TU_ASSERT(a_row_last, clk, rst_n,
        (out_ch.valid && !out_ch.last) |-> (out_ch.out_row != ROW_LAST))

endmodule

// ===== tb/sv/m4tu_checker.sv =====
`timescale 1ns / 100ps

module m4tu_checker import m4tu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    m4tu_in_if   in_mon,
    m4tu_out_if  out_mon,
    output int   mismatches,
    output int   rows_outstanding
);

    // One result word as the block should deliver it
    typedef struct {
        word_t            elem [DIM];
        logic [ROW_W-1:0] row;
        logic             last;
        logic             overflow;
    } product_row_t;

    word_t        mat_a [DIM][DIM];
    word_t        mat_b [DIM][DIM];
    product_row_t pending_rows [$];

    // Return A to identity and B to zero, drop anything outstanding
    task automatic clear_state();
        int r;
        int c;
        for (r = 0; r < DIM; r++)
        begin
            for (c = 0; c < DIM; c++)
            begin
                mat_a[r][c] = (r == c) ? word_t'(longint'(1) << FRAC_BITS_DEF) : '0;
                mat_b[r][c] = '0;
            end
        end
        pending_rows.delete();
    endtask

    // Product rounded to nearest, ties towards plus infinity
    function automatic longint mul_round(word_t a, word_t b);
        longint prod;
        prod = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC_BITS_DEF - 1));
        return prod >>> FRAC_BITS_DEF;
    endfunction

    // Exact four-term sum of rounded products
    function automatic longint dot4(word_t a [DIM], word_t b [DIM]);
        longint sum;
        int     i;
        sum = 0;
        for (i = 0; i < DIM; i++)
            sum += mul_round(a[i], b[i]);
        return sum;
    endfunction

    // Clamp the final sum to 32 bits and raise the flag on clipping
    function automatic word_t clamp_word(longint sum, inout logic ovf);
        if (sum > longint'(32'sh7FFF_FFFF))
        begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (sum < -longint'(64'sh8000_0000))
        begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return word_t'(sum);
    endfunction

    // Update the stored matrices and queue the rows this word causes
    task automatic compute_products();
        logic [MODE_W-1:0] mode;
        logic [ROW_W-1:0]  sel;
        word_t             elem [DIM];
        word_t             col [DIM];
        product_row_t      res;
        int                r;
        int                c;
        int                i;
        mode    = in_mon.mode;
        sel     = in_mon.row_sel;
        elem[0] = in_mon.elem0;
        elem[1] = in_mon.elem1;
        elem[2] = in_mon.elem2;
        elem[3] = in_mon.elem3;
        case (mode)
            MODE_LOAD_A:
            begin
                mat_a[sel] = elem;
            end
            MODE_XFORM:
            begin
                res.overflow = 1'b0;
                for (r = 0; r < DIM; r++)
                    res.elem[r] = clamp_word(dot4(mat_a[r], elem), res.overflow);
                res.row  = '0;
                res.last = 1'b1;
                pending_rows.push_back(res);
            end
            MODE_LOAD_B:
            begin
                mat_b[sel] = elem;
                if (sel == ROW_LAST)
                begin
                    for (r = 0; r < DIM; r++)
                    begin
                        res.overflow = 1'b0;
                        for (c = 0; c < DIM; c++)
                        begin
                            for (i = 0; i < DIM; i++)
                                col[i] = mat_b[i][c];
                            res.elem[c] = clamp_word(dot4(mat_a[r], col), res.overflow);
                        end
                        res.row  = ROW_W'(r);
                        res.last = (r == DIM - 1);
                        pending_rows.push_back(res);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Match a delivered word against the oldest outstanding row
    task automatic compare_row();
        product_row_t want;
        word_t        got [DIM];
        int           i;
        got[0] = out_mon.out0;
        got[1] = out_mon.out1;
        got[2] = out_mon.out2;
        got[3] = out_mon.out3;
        if (pending_rows.size() == 0)
        begin
            $error("unexpected result word: out_row %0d, out0 %h", out_mon.out_row, got[0]);
            mismatches++;
            return;
        end
        want = pending_rows.pop_front();
        for (i = 0; i < DIM; i++)
        begin
            if (got[i] !== want.elem[i])
            begin
                $error("out%0d: expected %h, actual %h", i, want.elem[i], got[i]);
                mismatches++;
            end
        end
        if (out_mon.out_row !== want.row)
        begin
            $error("out_row: expected %0d, actual %0d", want.row, out_mon.out_row);
            mismatches++;
        end
        if (out_mon.last !== want.last)
        begin
            $error("last: expected %b, actual %b", want.last, out_mon.last);
            mismatches++;
        end
        if (out_mon.overflow !== want.overflow)
        begin
            $error("overflow: expected %b, actual %b", want.overflow, out_mon.overflow);
            mismatches++;
        end
    endtask

    // Sample both channels at the edge; outputs before inputs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_state();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
                compare_row();
            if (in_mon.valid && in_mon.ready)
                compute_products();
        end
        rows_outstanding = pending_rows.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import m4tu_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int    RANDOM_WORDS = 470;
    localparam int    IDLE_LIMIT   = 2000;
    localparam int    DRAIN_CYCLES = 40;
    localparam word_t ONE          = word_t'(longint'(1) << FRAC_BITS_DEF);
    localparam word_t WORD_MAX     = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN     = 32'sh8000_0000;

    logic clk = 1'b0;
    logic rst_n;

    int mismatches;
    int rows_outstanding;
    int words_sent;
    int burst_left;
    int idle_cycles;

    int   stall_kind;
    int   phase_left;
    int   hold_left;
    logic hold_level;

    m4tu_in_if  in_ch ();
    m4tu_out_if out_ch ();

    matrix4_transform_unit #(
        .FRAC_BITS (FRAC_BITS_DEF)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    m4tu_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_mon           (in_ch),
        .out_mon          (out_ch),
        .mismatches       (mismatches),
        .rows_outstanding (rows_outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Element mix: extremes, unit values, raw bit patterns, small values around zero
    function automatic word_t rand_elem();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return WORD_MAX;
        else if (pick == 1)
            return WORD_MIN;
        else if (pick == 2)
            return ONE;
        else if (pick == 3)
            return -ONE;
        else if (pick == 4)
            return '0;
        else if (pick < 9)
            return word_t'($urandom());
        return word_t'($urandom_range(0, 32'h000F_FFFF)) - word_t'(32'h0008_0000);
    endfunction

    function automatic logic [ROW_W-1:0] rand_sel();
        return ROW_W'($urandom_range(0, DIM - 1));
    endfunction

    // Present one word, hold it until taken, then maybe open a gap
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] sel,
                             input word_t e0, input word_t e1, input word_t e2, input word_t e3);
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.row_sel <= sel;
        in_ch.elem0   <= e0;
        in_ch.elem1   <= e1;
        in_ch.elem2   <= e2;
        in_ch.elem3   <= e3;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Receiver: free, coin-toss, light or long stalls, switching by phase
    initial
    begin
        out_ch.ready = 1'b0;
        phase_left   = 0;
        hold_left    = 0;
        hold_level   = 1'b1;
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                stall_kind = $urandom_range(0, 3);
                phase_left = $urandom_range(50, 300);
            end
            phase_left--;
            case (stall_kind)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) != 0);
                2: out_ch.ready <= ($urandom_range(0, 7) != 0);
                default:
                begin
                    if (hold_left == 0)
                    begin
                        hold_level = ~hold_level;
                        hold_left  = hold_level ? $urandom_range(1, 6) : $urandom_range(1, 30);
                    end
                    hold_left--;
                    out_ch.ready <= hold_level;
                end
            endcase
        end
    end

    // Stop the run if neither channel moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        int r;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_LOAD_A;
        in_ch.row_sel = '0;
        in_ch.elem0   = '0;
        in_ch.elem1   = '0;
        in_ch.elem2   = '0;
        in_ch.elem3   = '0;
        idle_cycles   = 0;
        words_sent    = 0;
        burst_left    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity after reset; row select ignored for a transform
        send_word(MODE_XFORM, 2'd2, WORD_MAX, WORD_MIN, ONE, -ONE);
        // Compose against B with only row 3 loaded
        send_word(MODE_LOAD_B, ROW_LAST, ONE, 2 * ONE, -3 * ONE, 32'sd12345);

        // Rows that clip high, clip low, nearly cancel, and hit rounding ties
        send_word(MODE_LOAD_A, 2'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send_word(MODE_LOAD_A, 2'd1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_word(MODE_LOAD_A, 2'd2, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN);
        send_word(MODE_LOAD_A, ROW_LAST, 32'sd1, -32'sd1, -32'sd1, 32'sd0);
        send_word(MODE_XFORM, 2'd0, ONE, ONE, ONE, ONE);
        send_word(MODE_XFORM, 2'd3, 32'sd32768, 32'sd32768, 32'sd98304, 32'sd0);
        send_word(MODE_XFORM, 2'd1, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_word(MODE_XFORM, 2'd0, '0, '0, '0, '0);
        send_word(MODE_XFORM, 2'd0, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

        // Full compose with extreme B
        send_word(MODE_LOAD_B, 2'd0, WORD_MAX, WORD_MIN, ONE, '0);
        send_word(MODE_LOAD_B, 2'd1, WORD_MIN, WORD_MAX, -ONE, 32'sd1);
        send_word(MODE_LOAD_B, 2'd2, ONE, -ONE, WORD_MAX, WORD_MIN);
        send_word(MODE_LOAD_B, ROW_LAST, -32'sd1, 32'sd32768, WORD_MIN, WORD_MAX);

        // Unused mode must leave both matrices alone
        send_word(MODE_UNUSED, 2'd3, WORD_MAX, WORD_MIN, -32'sd1, ONE);
        send_word(MODE_UNUSED, 2'd0, '0, '0, '0, '0);

        // Back to identity A and recompose with a new row 3 of B
        send_word(MODE_LOAD_A, 2'd0, ONE, '0, '0, '0);
        send_word(MODE_LOAD_A, 2'd1, '0, ONE, '0, '0);
        send_word(MODE_LOAD_A, 2'd2, '0, '0, ONE, '0);
        send_word(MODE_LOAD_A, ROW_LAST, '0, '0, '0, ONE);
        send_word(MODE_LOAD_B, ROW_LAST, 32'sd7, -32'sd7, ONE, -ONE);
        send_word(MODE_XFORM, 2'd0, WORD_MAX, WORD_MIN, 32'sd1, -32'sd1);

        // Random traffic: single words of every mode mixed with whole and broken-off load sequences
        while (words_sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_word(MODE_XFORM, rand_sel(), rand_elem(), rand_elem(), rand_elem(),
                          rand_elem());
            end
            else if (pick < 50)
            begin
                send_word(MODE_LOAD_A, rand_sel(), rand_elem(), rand_elem(), rand_elem(),
                          rand_elem());
            end
            else if (pick < 55)
            begin
                for (r = 0; r < DIM; r++)
                    send_word(MODE_LOAD_A, ROW_W'(r), rand_elem(), rand_elem(), rand_elem(),
                              rand_elem());
            end
            else if (pick < 80)
            begin
                for (r = 0; r < DIM; r++)
                    send_word(MODE_LOAD_B, ROW_W'(r), rand_elem(), rand_elem(), rand_elem(),
                              rand_elem());
            end
            else if (pick < 88)
            begin
                send_word(MODE_LOAD_B, rand_sel(), rand_elem(), rand_elem(), rand_elem(),
                          rand_elem());
            end
            else if (pick < 93)
            begin
                // Break off a compose before row 3 and transform instead
                for (r = 0; r < DIM - 1; r++)
                    send_word(MODE_LOAD_B, ROW_W'(r), rand_elem(), rand_elem(), rand_elem(),
                              rand_elem());
                send_word(MODE_XFORM, rand_sel(), rand_elem(), rand_elem(), rand_elem(),
                          rand_elem());
            end
            else
            begin
                send_word(MODE_UNUSED, rand_sel(), rand_elem(), rand_elem(), rand_elem(),
                          rand_elem());
            end
        end

        // Drain: let every outstanding row arrive, then settle
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (rows_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
